[hw/rtl/connection_slot_tracker_unit_defines.svh]
// Assertion macros used by the connection slot tracker checker.
`ifndef CONNECTION_SLOT_TRACKER_UNIT_DEFINES_SVH
`define CONNECTION_SLOT_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CST_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("cst check failed");

// Next-cycle implication, disabled during reset.
`define CST_ASSERT_NXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("cst check failed");

`endif

[hw/rtl/cst_pkg.sv]
// Types, codes and helper functions of the connection slot tracker.
`timescale 1ns / 1ps
package cst_pkg;

    typedef enum logic [3:0] {
        FN_REGISTER   = 4'd0,
        FN_UNREGISTER = 4'd1,
        FN_ADD_RD     = 4'd2,
        FN_REM_RD     = 4'd3,
        FN_ADD_WR     = 4'd4,
        FN_REM_WR     = 4'd5,
        FN_ADD_AC     = 4'd6,
        FN_REM_AC     = 4'd7,
        FN_ADD_CO     = 4'd8,
        FN_REM_CO     = 4'd9,
        FN_SET_ERROR  = 4'd10,
        FN_UPDATE     = 4'd11,
        FN_QUERY      = 4'd12,
        FN_CLAIM      = 4'd13,
        FN_RELEASE    = 4'd14,
        FN_SWEEP      = 4'd15
    } cst_func_t;

    // Connection state codes
    localparam logic [3:0] CS_UNUSED        = 4'd0;
    localparam logic [3:0] CS_LISTENING     = 4'd1;
    localparam logic [3:0] CS_ACCEPTING     = 4'd2;
    localparam logic [3:0] CS_CONNECTING    = 4'd4;
    localparam logic [3:0] CS_CONNECTED     = 4'd5;
    localparam logic [3:0] CS_READING       = 4'd6;
    localparam logic [3:0] CS_WRITING       = 4'd7;
    localparam logic [3:0] CS_READWRITE     = 4'd8;
    localparam logic [3:0] CS_DISCONNECTING = 4'd9;
    localparam logic [3:0] CS_ERROR         = 4'd10;

    // Counter lanes
    localparam logic [1:0] CNT_RD = 2'd0;
    localparam logic [1:0] CNT_WR = 2'd1;
    localparam logic [1:0] CNT_AC = 2'd2;
    localparam logic [1:0] CNT_CO = 2'd3;

    localparam logic [7:0] ETIMEDOUT = 8'd110;
    localparam logic [31:0] TIMEOUT_RESET = 32'd60;

    typedef struct packed {
        cst_func_t   func;
        logic [15:0] fd;
        logic [3:0]  start_state;
        logic [1:0]  peer_role;
        logic [7:0]  error_value;
        logic [31:0] write_gen;
        logic [15:0] write_tag;
        logic [31:0] now_seconds;
        logic [9:0]  sweep_slot;
    } cst_item_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  state;
        logic        has_reads;
        logic        has_writes;
        logic [31:0] generation;
        logic        gate_grant;
        logic        next_valid;
        logic [15:0] next_tag;
        logic        timed_out;
        logic [15:0] closed_fd;
        logic        queue_overflow;
    } cst_result_t;

    // Fixed-width part of one slot record
    typedef struct packed {
        logic        allocated;
        logic        fd_valid;
        logic [15:0] fd;
        logic [3:0]  state;
        logic [1:0]  role;
        logic [7:0]  error;
        logic [31:0] generation;
        logic [31:0] last_active;
        logic        gate_busy;
    } cst_meta_t;

    typedef enum logic [2:0] {
        CST_CLEAR,
        CST_IDLE,
        CST_DIV,
        CST_READ,
        CST_TAG,
        CST_EXEC
    } cst_fsm_t;

    // State implied by the read and write counters alone
    function automatic logic [3:0] rw_state(input logic rd_nz, input logic wr_nz);
        if (rd_nz) begin
            return wr_nz ? CS_READWRITE : CS_READING;
        end
        return wr_nz ? CS_WRITING : CS_CONNECTED;
    endfunction

endpackage

[hw/rtl/cst_slot_index.sv]
// Slot index = fd modulo slot count, by reciprocal multiply; the quotient is registered.
`timescale 1ns / 1ps
module cst_slot_index import cst_pkg::*; #(
    parameter int SLOT_COUNT = 1024,
    parameter int SLOT_BITS  = 10
) (
    input  logic                 aclk,
    input  logic                 load,
    input  logic [15:0]          fd_i,
    output logic [SLOT_BITS-1:0] slot_o
);
    localparam logic [32:0] RECIP = 33'((64'd4294967296 + 64'(SLOT_COUNT) - 64'd1)
                                        / 64'(SLOT_COUNT));

    logic [15:0] quot_reg;
    logic [48:0] prod;
    logic [32:0] back;
    logic [15:0] rem;

    // quotient estimate is exact for 16-bit dividends
    assign prod = 49'(fd_i) * 49'(RECIP);

    always_ff @(posedge aclk) begin
        if (load) begin
            quot_reg <= prod[47:32];
        end
    end

    assign back   = 33'(quot_reg) * 33'(SLOT_COUNT);
    assign rem    = fd_i - back[15:0];
    assign slot_o = rem[SLOT_BITS-1:0];

endmodule

[hw/rtl/cst_slot_update.sv]
// Read-modify-write logic for one slot record and the item's result.
`timescale 1ns / 1ps
module cst_slot_update import cst_pkg::*; #(
    parameter int QUEUE_DEPTH = 4,
    parameter int COUNT_BITS  = 16,
    parameter int QB          = 2,
    parameter int CTB         = 3
) (
    input  cst_item_t                        item,
    input  logic [31:0]                      limit,
    input  logic                             sweep_ok,
    input  cst_meta_t                        meta_i,
    input  logic [3:0][COUNT_BITS-1:0]       cnt_i,
    input  logic [QB-1:0]                    head_i,
    input  logic [CTB-1:0]                   qcnt_i,
    input  logic [15:0]                      head_tag,
    output cst_meta_t                        meta_o,
    output logic [3:0][COUNT_BITS-1:0]       cnt_o,
    output logic [QB-1:0]                    head_o,
    output logic [CTB-1:0]                   qcnt_o,
    output logic                             tag_we,
    output logic [QB-1:0]                    tag_pos,
    output cst_result_t                      res
);
    localparam int SW = CTB + 1;

    logic        match;
    logic        found;
    logic [3:0]  fsub;
    logic [1:0]  k;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] head_sum;
    logic [31:0] idle;

    assign match = meta_i.allocated && meta_i.fd_valid && (meta_i.fd == item.fd);
    assign fsub  = item.func - FN_ADD_RD;
    assign k     = fsub[2:1];
    assign idle  = item.now_seconds - meta_i.last_active;

    // ring positions, both sums stay below twice the depth
    always_comb begin
        tail_sum = SW'(head_i) + SW'(qcnt_i);
        if (tail_sum >= SW'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SW'(QUEUE_DEPTH);
        end
        head_sum = SW'(head_i) + SW'(1);
        if (head_sum >= SW'(QUEUE_DEPTH)) begin
            head_sum = head_sum - SW'(QUEUE_DEPTH);
        end
    end

    always_comb begin
        meta_o  = meta_i;
        cnt_o   = cnt_i;
        head_o  = head_i;
        qcnt_o  = qcnt_i;
        tag_we  = 1'b0;
        tag_pos = tail_sum[QB-1:0];
        res     = '0;
        found   = match;

        case (item.func) inside
            FN_SWEEP: begin
                found = 1'b0;
                if (sweep_ok && meta_i.allocated && meta_i.fd_valid &&
                    meta_i.state != CS_UNUSED &&
                    item.now_seconds > meta_i.last_active && idle > limit) begin
                    res.timed_out      = 1'b1;
                    res.closed_fd      = meta_i.fd;
                    meta_o.error       = ETIMEDOUT;
                    meta_o.last_active = item.now_seconds;
                    meta_o.state       = CS_UNUSED;
                    meta_o.fd_valid    = 1'b0;
                    meta_o.gate_busy   = 1'b0;
                    cnt_o              = '0;
                    head_o             = '0;
                    qcnt_o             = '0;
                end
            end
            FN_REGISTER: begin
                if (!match && (!meta_i.allocated || meta_i.state == CS_UNUSED)) begin
                    meta_o.generation = meta_i.allocated ? meta_i.generation + 32'd1
                                                         : 32'd1;
                    meta_o.error     = '0;
                    meta_o.fd        = item.fd;
                    meta_o.fd_valid  = 1'b1;
                    meta_o.allocated = 1'b1;
                    found            = 1'b1;
                end
                if (found) begin
                    meta_o.state = (item.start_state > CS_ERROR) ? CS_ERROR
                                                                 : item.start_state;
                    meta_o.role        = item.peer_role;
                    meta_o.last_active = item.now_seconds;
                    meta_o.gate_busy   = 1'b0;
                    cnt_o              = '0;
                    head_o             = '0;
                    qcnt_o             = '0;
                end
            end
            default: begin
                if (!match) begin
                    if (item.func == FN_CLAIM) begin
                        res.gate_grant = 1'b1;
                    end
                end else begin
                    case (item.func) inside
                        FN_UNREGISTER: begin
                            meta_o.state     = CS_UNUSED;
                            meta_o.fd_valid  = 1'b0;
                            meta_o.gate_busy = 1'b0;
                            cnt_o            = '0;
                            head_o           = '0;
                            qcnt_o           = '0;
                        end
                        FN_ADD_RD, FN_ADD_WR, FN_ADD_AC, FN_ADD_CO: begin
                            meta_o.last_active = item.now_seconds;
                            if (cnt_i[k] != '1) begin
                                cnt_o[k] = cnt_i[k] + COUNT_BITS'(1);
                            end
                            if (k == CNT_RD || k == CNT_WR) begin
                                if (cnt_o[CNT_RD] != '0 && cnt_o[CNT_WR] != '0) begin
                                    meta_o.state = CS_READWRITE;
                                end else begin
                                    meta_o.state = (k == CNT_RD) ? CS_READING : CS_WRITING;
                                end
                            end else begin
                                meta_o.state = (k == CNT_AC) ? CS_ACCEPTING : CS_CONNECTING;
                            end
                        end
                        FN_REM_RD, FN_REM_WR, FN_REM_AC, FN_REM_CO: begin
                            meta_o.last_active = item.now_seconds;
                            if (cnt_i[k] != '0) begin
                                cnt_o[k] = cnt_i[k] - COUNT_BITS'(1);
                                if (k == CNT_RD || k == CNT_WR) begin
                                    meta_o.state = rw_state(cnt_o[CNT_RD] != '0,
                                                            cnt_o[CNT_WR] != '0);
                                end else if (cnt_o[k] == '0) begin
                                    if (k == CNT_AC && meta_i.state == CS_ACCEPTING) begin
                                        meta_o.state = CS_LISTENING;
                                    end
                                    if (k == CNT_CO && meta_i.state == CS_CONNECTING) begin
                                        meta_o.state = CS_CONNECTED;
                                    end
                                end
                            end
                        end
                        FN_SET_ERROR: begin
                            meta_o.state       = CS_ERROR;
                            meta_o.error       = item.error_value;
                            meta_o.last_active = item.now_seconds;
                        end
                        FN_UPDATE: begin
                            if (cnt_i[CNT_RD] != '0 || cnt_i[CNT_WR] != '0) begin
                                meta_o.state = rw_state(cnt_i[CNT_RD] != '0,
                                                        cnt_i[CNT_WR] != '0);
                            end else if (cnt_i[CNT_AC] != '0) begin
                                meta_o.state = CS_ACCEPTING;
                            end else if (cnt_i[CNT_CO] != '0) begin
                                meta_o.state = CS_CONNECTING;
                            end else if (meta_i.state == CS_ERROR ||
                                         meta_i.state == CS_DISCONNECTING ||
                                         meta_i.state == CS_UNUSED) begin
                                meta_o.state = meta_i.state;
                            end else begin
                                meta_o.state = CS_CONNECTED;
                            end
                        end
                        FN_CLAIM: begin
                            if (!meta_i.gate_busy) begin
                                meta_o.gate_busy = 1'b1;
                                res.gate_grant   = 1'b1;
                            end else if (qcnt_i < CTB'(QUEUE_DEPTH)) begin
                                tag_we = 1'b1;
                                qcnt_o = qcnt_i + CTB'(1);
                            end else begin
                                res.queue_overflow = 1'b1;
                            end
                        end
                        FN_RELEASE: begin
                            if (meta_i.generation == item.write_gen) begin
                                if (qcnt_i != '0) begin
                                    res.next_valid = 1'b1;
                                    res.next_tag   = head_tag;
                                    head_o         = head_sum[QB-1:0];
                                    qcnt_o         = qcnt_i - CTB'(1);
                                end else begin
                                    meta_o.gate_busy = 1'b0;
                                end
                            end
                        end
                        default: begin
                            // query leaves the slot as it is
                        end
                    endcase
                end
            end
        endcase

        // slot view after the operation
        if (found) begin
            res.found      = 1'b1;
            res.state      = meta_o.state;
            res.has_reads  = cnt_o[CNT_RD] != '0;
            res.has_writes = cnt_o[CNT_WR] != '0;
            res.generation = meta_o.generation;
        end
    end

endmodule

[hw/rtl/connection_slot_tracker_unit.sv]
// Top level of the connection slot tracker: sequencer, slot and tag memories.
`timescale 1ns / 1ps
// Connection slot tracker.
// Input channel s_*: one item per handshake; s_tuser carries the operation
// code, s_tdata the operands. Output channel m_*: exactly one result item per
// input item, in order. cfg_wr_en/cfg_wr_data write the idle timeout limit.
// Each item is accepted, its slot index is formed by a reciprocal multiply
// (quotient registered), the slot record is read from the slot memory, the
// writer-tag memory is read at the queue head, and the record is updated and
// written back while the result is loaded. A new item is accepted only
// after the current one has been written back. After reset the slot memory
// is swept clear, one slot per cycle, from slot 0 to SLOT_COUNT-1; no item
// is accepted during the sweep. The timeout limit resets to 60. A result
// waits in the output register while m_tready is low; the next item is
// accepted meanwhile but held at write-back until the output register is
// free.
module connection_slot_tracker_unit import cst_pkg::*; #(
    parameter int SLOT_COUNT  = 1024,
    parameter int QUEUE_DEPTH = 4,
    parameter int COUNT_BITS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // fd, start_state, peer_role, error_value, write_gen, write_tag,
    // now_seconds, sweep_slot
    input  logic [119:0] s_tdata,
    // func
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found, state, has_reads, has_writes, generation, gate_grant, next_valid,
    // next_tag, timed_out, closed_fd, queue_overflow, zero pad
    output logic [79:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data
);
    localparam int SB     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int QB     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CTB    = $clog2(QUEUE_DEPTH + 1);
    localparam int TAB    = $clog2(SLOT_COUNT * QUEUE_DEPTH);
    localparam int META_W = $bits(cst_meta_t);
    localparam int SLOT_W = META_W + 4 * COUNT_BITS + QB + CTB;

    cst_fsm_t    state_reg, state_next;
    logic [SB-1:0] clr_reg, clr_next;
    logic [31:0] limit_reg;
    cst_item_t   item_reg;
    logic [SB-1:0] addr_reg;
    logic [TAB-1:0] tbase_reg;
    logic [SLOT_W-1:0] slot_rd_reg;
    logic [15:0] tag_rd_reg;
    logic        m_tvalid_reg;
    cst_result_t res_reg;

    logic [SLOT_W-1:0] slot_mem [SLOT_COUNT];
    logic [15:0]       tag_mem  [SLOT_COUNT * QUEUE_DEPTH];

    logic [SB-1:0] idx;
    logic [SB-1:0] sw_slot;
    logic [SB+9:0] sw_wide;
    logic [SB-1:0] addr;
    logic          sweep_ok;
    logic          out_free;
    logic          slot_we;
    logic [SB-1:0] slot_waddr;
    logic [SLOT_W-1:0] slot_wdata;
    logic          rd_en;
    logic          tag_rd_en;
    logic          tag_wr_en;
    logic          exec_go;

    cst_meta_t                  meta_i, meta_o;
    logic [3:0][COUNT_BITS-1:0] cnt_i, cnt_o;
    logic [QB-1:0]              head_i, head_o, tag_pos;
    logic [CTB-1:0]             qcnt_i, qcnt_o;
    logic                       tag_we;
    cst_result_t                res;

    // slot index from fd
    cst_slot_index #(
        .SLOT_COUNT(SLOT_COUNT),
        .SLOT_BITS (SB)
    ) u_index (
        .aclk  (aclk),
        .load  (state_reg == CST_DIV),
        .fd_i  (item_reg.fd),
        .slot_o(idx)
    );

    assign sw_wide  = {SB'(0), item_reg.sweep_slot};
    assign sw_slot  = sw_wide[SB-1:0];
    assign sweep_ok = 17'(item_reg.sweep_slot) < 17'(SLOT_COUNT);
    assign addr     = (item_reg.func == FN_SWEEP) ? sw_slot : idx;
    assign out_free = !m_tvalid_reg || m_tready;

    // unpack the stored record
    assign meta_i = slot_rd_reg[META_W-1:0];
    assign cnt_i  = slot_rd_reg[META_W +: 4*COUNT_BITS];
    assign head_i = slot_rd_reg[META_W+4*COUNT_BITS +: QB];
    assign qcnt_i = slot_rd_reg[META_W+4*COUNT_BITS+QB +: CTB];

    cst_slot_update #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .COUNT_BITS (COUNT_BITS),
        .QB         (QB),
        .CTB        (CTB)
    ) u_update (
        .item    (item_reg),
        .limit   (limit_reg),
        .sweep_ok(sweep_ok),
        .meta_i  (meta_i),
        .cnt_i   (cnt_i),
        .head_i  (head_i),
        .qcnt_i  (qcnt_i),
        .head_tag(tag_rd_reg),
        .meta_o  (meta_o),
        .cnt_o   (cnt_o),
        .head_o  (head_o),
        .qcnt_o  (qcnt_o),
        .tag_we  (tag_we),
        .tag_pos (tag_pos),
        .res     (res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            CST_CLEAR: begin
                clr_next = clr_reg + SB'(1);
                if (clr_reg == SB'(SLOT_COUNT - 1)) begin
                    state_next = CST_IDLE;
                end
            end
            CST_IDLE: begin
                if (s_tvalid) begin
                    state_next = CST_DIV;
                end
            end
            CST_DIV:  state_next = CST_READ;
            CST_READ: state_next = CST_TAG;
            CST_TAG:  state_next = CST_EXEC;
            CST_EXEC: begin
                if (out_free) begin
                    state_next = CST_IDLE;
                end
            end
            default:  state_next = CST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready   = 1'b0;
        rd_en      = 1'b0;
        tag_rd_en  = 1'b0;
        exec_go    = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = addr_reg;
        slot_wdata = {qcnt_o, head_o, cnt_o, meta_o};
        unique case (state_reg)
            CST_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
            end
            CST_IDLE: s_tready = 1'b1;
            CST_READ: rd_en = 1'b1;
            CST_TAG:  tag_rd_en = 1'b1;
            CST_EXEC: begin
                exec_go = out_free;
                slot_we = out_free;
            end
            default: begin
            end
        endcase
    end

    assign tag_wr_en = exec_go && tag_we;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= CST_CLEAR;
            clr_reg      <= '0;
            limit_reg    <= TIMEOUT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (exec_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= {cst_func_t'(s_tuser), s_tdata[15:0], s_tdata[19:16],
                         s_tdata[21:20], s_tdata[29:22], s_tdata[61:30],
                         s_tdata[77:62], s_tdata[109:78], s_tdata[119:110]};
        end
        if (rd_en) begin
            addr_reg  <= addr;
            tbase_reg <= TAB'(addr) * TAB'(QUEUE_DEPTH);
        end
        if (exec_go) begin
            res_reg <= res;
        end
    end

    // slot memory
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (rd_en) begin
            slot_rd_reg <= slot_mem[addr];
        end
    end

    // writer tag memory
    always_ff @(posedge aclk) begin
        if (tag_wr_en) begin
            tag_mem[tbase_reg + TAB'(tag_pos)] <= item_reg.write_tag;
        end
        if (tag_rd_en) begin
            tag_rd_reg <= tag_mem[tbase_reg + TAB'(head_i)];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, res_reg.queue_overflow, res_reg.closed_fd,
                       res_reg.timed_out, res_reg.next_tag, res_reg.next_valid,
                       res_reg.gate_grant, res_reg.generation, res_reg.has_writes,
                       res_reg.has_reads, res_reg.state, res_reg.found};

endmodule

[hw/rtl/cst_checker.sv]
// Port-level checks of the connection slot tracker and their bind.
`timescale 1ns / 1ps
`include "connection_slot_tracker_unit_defines.svh"
module cst_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [79:0]  m_tdata
);
    // a stalled result stays offered
    `CST_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // no slot view without a match
    `CST_ASSERT_IMP(a_nofound_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[38:1] == 38'd0)
    // a grant and an overflow never come together
    `CST_ASSERT_IMP(a_claim_excl, aclk, aresetn, m_tvalid, !(m_tdata[39] && m_tdata[74]))
    // a timeout result carries no slot view
    `CST_ASSERT_IMP(a_timeout_only, aclk, aresetn, m_tvalid && m_tdata[57], !m_tdata[0] && !m_tdata[40])
endmodule

bind connection_slot_tracker_unit cst_checker u_cst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
